[rtl/core/wfh_pkg.sv]
// shared types and constants for the write frequency histogram monitor
// no dependencies; used by wfh_log4 and write_frequency_histogram
package wfh_pkg;

  localparam int ADDR_W      = 64;
  localparam int SIZE_W      = 7;
  localparam int CNT_W       = 32;
  localparam int HCNT_W      = 13;
  localparam int NUM_BINS    = 16;
  localparam int BIN_W       = 4;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 32;

  localparam logic [HCNT_W-1:0] HCNT_MAX = {HCNT_W{1'b1}};
  localparam logic [BIN_W-1:0]  LAST_BIN = BIN_W'(NUM_BINS - 1);

  // operation codes carried in tuser
  localparam logic OP_STORE  = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  // one binned counter coming out of the log4 unit
  typedef struct packed {
    logic             vld;
    logic [BIN_W-1:0] bin;
  } bin_upd_t;

endpackage

[rtl/core/write_frequency_histogram.sv]
// store item: one read and one write of the counter ram per word (read-modify-write)
// report item: a full-table scan of all WINDOW_WORDS counter words, a drain of the ram read
// and the binning stages, then 16 result items, which wait while the sink stalls
// one item at a time: tready is low while a store or report is in progress
// reset: synchronous, then a clearing pass over all WINDOW_WORDS words zeroes the ram
// before the first item is taken; window_base resets to zero
module write_frequency_histogram #(
  parameter int WINDOW_WORDS    = 4096,
  parameter int MAX_STORE_BYTES = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration: window_base
  input  logic                                cfg_wr_en,
  input  logic [wfh_pkg::ADDR_W-1:0]          cfg_wr_data,
  // input items
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [wfh_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // address[63:0], size_bytes[70:64]
  input  logic                                s_axis_tuser,  // operation
  // result items
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [wfh_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // bin[3:0], addresses_in_bin[16:4],
                                                             // total_addresses[29:17]
  output logic                                m_axis_tlast
);

  localparam int IDX_W = $clog2(WINDOW_WORDS);
  localparam int SZ_W  = ($clog2(MAX_STORE_BYTES + 4) > wfh_pkg::SIZE_W) ?
                         $clog2(MAX_STORE_BYTES + 4) : wfh_pkg::SIZE_W;
  localparam int WC_W  = $clog2((MAX_STORE_BYTES + 3) / 4 + 1);

  // sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_WR    = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0]                         state;
  logic [wfh_pkg::ADDR_W-1:0]         window_base;
  logic [wfh_pkg::ADDR_W-1:0]         cur_addr;
  logic [WC_W-1:0]                    words_left;
  logic [IDX_W-1:0]                   idx_cnt;
  logic [IDX_W-1:0]                   wr_idx;
  logic                               hit;
  logic [1:0]                         drain_cnt;
  logic                               rd_vld;
  logic [wfh_pkg::CNT_W-1:0]          rd_data;
  logic [wfh_pkg::HCNT_W-1:0]         hist [wfh_pkg::NUM_BINS];
  logic [wfh_pkg::HCNT_W-1:0]         total;
  logic [wfh_pkg::BIN_W-1:0]          out_bin;
  logic                               out_vld;
  wfh_pkg::bin_upd_t                  upd;

  // counter ram
  logic [wfh_pkg::CNT_W-1:0]          mem [WINDOW_WORDS];
  logic                               mem_we;
  logic [IDX_W-1:0]                   mem_waddr;
  logic [wfh_pkg::CNT_W-1:0]          mem_wdata;
  logic [IDX_W-1:0]                   mem_raddr;

  // input decode
  logic                               in_acc;
  logic [SZ_W-1:0]                    sz_ext;
  logic [SZ_W-1:0]                    sz_sat;
  logic [SZ_W-1:0]                    sz_sum;
  logic [WC_W-1:0]                    words_in;
  logic [wfh_pkg::ADDR_W-1:0]         base_aligned;
  logic [wfh_pkg::ADDR_W-1:0]         diff;
  logic                               hit_now;
  logic                               out_acc;

  assign s_axis_tready = (state == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_acc       = out_vld && m_axis_tready;

  // store size: saturate, then ceil(size/4) words with a floor of one word
  assign sz_ext   = SZ_W'(s_axis_tdata[wfh_pkg::ADDR_W +: wfh_pkg::SIZE_W]);
  assign sz_sat   = (sz_ext > SZ_W'(MAX_STORE_BYTES)) ? SZ_W'(MAX_STORE_BYTES) : sz_ext;
  assign sz_sum   = sz_sat + SZ_W'(3);
  assign words_in = (sz_sat <= SZ_W'(4)) ? WC_W'(1) : WC_W'(sz_sum >> 2);

  // word index inside the window, modulo 2^64
  assign base_aligned = {window_base[wfh_pkg::ADDR_W-1:2], 2'b00};
  assign diff         = cur_addr - base_aligned;
  assign hit_now      = (diff[wfh_pkg::ADDR_W-1:2] < (wfh_pkg::ADDR_W - 2)'(WINDOW_WORDS));

  // ram port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_cnt;
    mem_wdata = '0;
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (state == S_WR) begin
      mem_we    = hit && (rd_data != {wfh_pkg::CNT_W{1'b1}});
      mem_waddr = wr_idx;
      mem_wdata = rd_data + wfh_pkg::CNT_W'(1);
    end
    mem_raddr = (state == S_SCAN) ? idx_cnt : diff[IDX_W+1:2];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  // binning unit fed by the scan reads
  wfh_log4 u_log4 (
    .clk    (clk),
    .rst    (rst),
    .in_vld (rd_vld),
    .in_cnt (rd_data),
    .upd    (upd)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      window_base <= '0;
    end else if (cfg_wr_en) begin
      window_base <= cfg_wr_data;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      idx_cnt   <= '0;
      drain_cnt <= '0;
      rd_vld    <= 1'b0;
      out_vld   <= 1'b0;
      out_bin   <= '0;
    end else begin
      rd_vld <= (state == S_SCAN);
      unique case (state)
        S_CLEAR: begin
          if (idx_cnt == IDX_W'(WINDOW_WORDS - 1)) begin
            idx_cnt <= '0;
            state   <= S_IDLE;
          end else begin
            idx_cnt <= idx_cnt + IDX_W'(1);
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            if (s_axis_tuser == wfh_pkg::OP_REPORT) begin
              idx_cnt <= '0;
              state   <= S_SCAN;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_RD: begin
          state <= S_WR;
        end
        S_WR: begin
          if (words_left == WC_W'(1)) begin
            state <= S_IDLE;
          end else begin
            state <= S_RD;
          end
        end
        S_SCAN: begin
          if (idx_cnt == IDX_W'(WINDOW_WORDS - 1)) begin
            idx_cnt   <= '0;
            drain_cnt <= '0;
            state     <= S_DRAIN;
          end else begin
            idx_cnt <= idx_cnt + IDX_W'(1);
          end
        end
        S_DRAIN: begin
          // wait for the ram read and the two binning stages to empty
          if (drain_cnt == 2'd2) begin
            out_bin <= '0;
            out_vld <= 1'b1;
            state   <= S_EMIT;
          end else begin
            drain_cnt <= drain_cnt + 2'd1;
          end
        end
        S_EMIT: begin
          if (out_acc) begin
            if (out_bin == wfh_pkg::LAST_BIN) begin
              out_vld <= 1'b0;
              state   <= S_IDLE;
            end else begin
              out_bin <= out_bin + wfh_pkg::BIN_W'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // store walk: current word address, words still to do, latched window hit
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur_addr   <= {s_axis_tdata[wfh_pkg::ADDR_W-1:2], 2'b00};
      words_left <= words_in;
    end else if (state == S_WR) begin
      cur_addr   <= cur_addr + wfh_pkg::ADDR_W'(4);
      words_left <= words_left - WC_W'(1);
    end
    if (state == S_RD) begin
      hit    <= hit_now;
      wr_idx <= diff[IDX_W+1:2];
    end
  end

  // histogram lanes: cleared when a report starts, counted up from the binning updates, shifted down while emitting
  always_ff @(posedge clk) begin
    if (in_acc && (s_axis_tuser == wfh_pkg::OP_REPORT)) begin
      for (int k = 0; k < wfh_pkg::NUM_BINS; k++) begin
        hist[k] <= '0;
      end
      total <= '0;
    end else if (upd.vld) begin
      for (int k = 0; k < wfh_pkg::NUM_BINS; k++) begin
        if ((upd.bin == wfh_pkg::BIN_W'(k)) && (hist[k] != wfh_pkg::HCNT_MAX)) begin
          hist[k] <= hist[k] + wfh_pkg::HCNT_W'(1);
        end
      end
      if (total != wfh_pkg::HCNT_MAX) begin
        total <= total + wfh_pkg::HCNT_W'(1);
      end
    end else if (out_acc) begin
      for (int k = 0; k < wfh_pkg::NUM_BINS - 1; k++) begin
        hist[k] <= hist[k+1];
      end
      hist[wfh_pkg::NUM_BINS-1] <= '0;
    end
  end

  // result item straight from registers
  assign m_axis_tvalid = out_vld;
  assign m_axis_tlast  = (out_bin == wfh_pkg::LAST_BIN);
  assign m_axis_tdata  = {2'b00, total, hist[0], out_bin};

`ifndef SYNTHESIS
  // no new item is taken while results are pending
  a_no_accept_while_emit: assert property (@(posedge clk) disable iff (rst)
    out_vld |-> !s_axis_tready)
    else $error("input accepted while results pending");

  // a bin never holds more words than the written total
  a_bin_le_total: assert property (@(posedge clk) disable iff (rst)
    out_vld |-> (hist[0] <= total))
    else $error("bin count exceeds total");

  // an accepted store starts its first counter read next cycle
  a_store_starts: assert property (@(posedge clk) disable iff (rst)
    (in_acc && (s_axis_tuser == wfh_pkg::OP_STORE)) |=> (state == S_RD))
    else $error("store did not start");

  // the binning pipeline is empty once results are shown
  a_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    out_vld |-> (!upd.vld && !rd_vld))
    else $error("binning still active during emit");
`endif

endmodule

[rtl/core/wfh_log4.sv]
// two-stage floor(log4) binning unit for nonzero write counters
// depends on wfh_pkg
module wfh_log4 (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_vld,
  input  logic [wfh_pkg::CNT_W-1:0]  in_cnt,
  output wfh_pkg::bin_upd_t          upd
);

  logic [wfh_pkg::NUM_BINS-1:0] pairs;
  logic [wfh_pkg::NUM_BINS-1:0] pairs_next;
  logic                         s1_vld;
  logic [wfh_pkg::BIN_W-1:0]    enc;

  // one bit per 2-bit digit of the count
  always_comb begin
    for (int k = 0; k < wfh_pkg::NUM_BINS; k++) begin
      pairs_next[k] = |in_cnt[2*k +: 2];
    end
  end

  // highest nonzero digit gives the bin
  always_comb begin
    enc = '0;
    for (int k = 0; k < wfh_pkg::NUM_BINS; k++) begin
      if (pairs[k]) begin
        enc = wfh_pkg::BIN_W'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    pairs   <= pairs_next;
    upd.bin <= enc;
    if (rst) begin
      s1_vld  <= 1'b0;
      upd.vld <= 1'b0;
    end else begin
      s1_vld  <= in_vld;
      upd.vld <= s1_vld && (|pairs);
    end
  end

endmodule
